// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files of the line tokenizer.
// Depends on nothing; each user supplies clk and rst_n in its own scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hw/rtl/alt_pkg.sv =====
// Package for the line tokenizer: column widths, character codes and
// character class functions. Depends on nothing.
`default_nettype none

package alt_pkg;

    // Column and position counters; MAX_LINE must fit in COL_W bits.
    localparam int COL_W = 13;
    localparam logic [COL_W-1:0] MAX_LINE = COL_W'(4096);

    // Character codes.
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Width of the packed result word.
    localparam int OUT_DATA_W = 40;

    // One-character separator tokens.
    function automatic logic is_sep(input logic [7:0] c);
        return (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_COMMA)
            || (c == CH_SEMI) || (c == CH_EQUAL);
    endfunction

    function automatic logic is_quote(input logic [7:0] c);
        return (c == CH_DQUOTE) || (c == CH_SQUOTE);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT)
            || (c == CH_FF) || (c == CH_CR);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/assembler_line_tokenizer_top.sv =====
// A result appears on the master side in the cycle after its request is accepted.
// Throughput: one byte per cycle while m_tready is held high; the scan state update and the result register
// sit behind one level of character classification.
// Reset: rst_n is asynchronous and active low; it returns the scanner to between
// tokens at column zero and empties the result register.
// Depends on alt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module assembler_line_tokenizer_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input byte stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_in
    input  wire logic        s_tlast,   // last_of_line
    // Classified byte stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] char_out, [8] in_token, [9] token_start, [22:10] token_column,
    // [23] is_quoted, [24] quote_error, [37:25] error_column, [39:38] zero
    output logic [alt_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic             m_tlast    // line_done
);

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_WORD  = 3'b010,
        MODE_QUOTE = 3'b100
    } scan_mode_t;

    typedef struct packed {
        logic [alt_pkg::COL_W-1:0] error_column;
        logic                      quote_error;
        logic                      is_quoted;
        logic [alt_pkg::COL_W-1:0] token_column;
        logic                      token_start;
        logic                      in_token;
        logic [7:0]                char_out;
    } result_t;

    localparam int RES_W = $bits(result_t);

    scan_mode_t                mode_reg, mode_next;
    logic                      quote_kind_reg, quote_kind_next;
    logic [alt_pkg::COL_W-1:0] position_reg, position_next;
    logic [alt_pkg::COL_W-1:0] start_col_reg, start_col_next;
    logic                      out_valid_reg, out_valid_next;
    result_t                   res_reg, res_next;
    logic                      last_reg, last_next;

    logic                      accept;
    logic [7:0]                c;
    logic [alt_pkg::COL_W-1:0] col;
    logic [7:0]                close_q;
    logic                      plain;
    logic                      tok, start, quoted;
    scan_mode_t                mode_scan;
    logic                      quote_kind_scan;
    logic [alt_pkg::COL_W-1:0] start_col_scan;

    // A new request is taken whenever the result register is empty or drains now.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign c        = s_tdata;

    // Per-byte scan: classify the byte against the current mode.
    always_comb
    begin
        col = (position_reg < alt_pkg::MAX_LINE) ? position_reg + 1'b1 : alt_pkg::MAX_LINE;
        close_q = quote_kind_reg ? alt_pkg::CH_SQUOTE : alt_pkg::CH_DQUOTE;
        plain = !alt_pkg::is_sep(c) && !alt_pkg::is_quote(c) && !alt_pkg::is_blank(c);
        tok = 1'b0;
        start = 1'b0;
        quoted = 1'b0;
        mode_scan = mode_reg;
        quote_kind_scan = quote_kind_reg;
        start_col_scan = start_col_reg;

        if (mode_reg == MODE_QUOTE)
        begin
            tok = 1'b1;
            quoted = 1'b1;
            if (c == close_q)
            begin
                mode_scan = MODE_IDLE;
            end
        end
        else if (mode_reg == MODE_WORD && plain)
        begin
            tok = 1'b1;
        end
        else
        begin
            // Between tokens, or the current word ends at this byte.
            mode_scan = MODE_IDLE;
            if (!alt_pkg::is_blank(c))
            begin
                tok = 1'b1;
                start = 1'b1;
                start_col_scan = col;
                if (alt_pkg::is_quote(c))
                begin
                    quoted = 1'b1;
                    quote_kind_scan = (c == alt_pkg::CH_SQUOTE);
                    mode_scan = MODE_QUOTE;
                end
                else if (plain)
                begin
                    mode_scan = MODE_WORD;
                end
            end
        end
    end

    // Result assembly and end-of-line handling.
    always_comb
    begin
        res_next.char_out     = c;
        res_next.in_token     = tok;
        res_next.token_start  = start;
        res_next.token_column = tok ? start_col_scan : '0;
        res_next.is_quoted    = quoted;
        res_next.quote_error  = s_tlast && (mode_scan == MODE_QUOTE);
        res_next.error_column = (s_tlast && (mode_scan == MODE_QUOTE)) ? col : '0;
        last_next = s_tlast;

        mode_next = mode_reg;
        quote_kind_next = quote_kind_reg;
        position_next = position_reg;
        start_col_next = start_col_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                mode_next = MODE_IDLE;
                quote_kind_next = 1'b0;
                position_next = '0;
                start_col_next = '0;
            end
            else
            begin
                mode_next = mode_scan;
                quote_kind_next = quote_kind_scan;
                start_col_next = start_col_scan;
                if (position_reg < alt_pkg::MAX_LINE)
                begin
                    position_next = position_reg + 1'b1;
                end
            end
        end

        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Scan state and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            quote_kind_reg <= 1'b0;
            position_reg   <= '0;
            start_col_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            quote_kind_reg <= quote_kind_next;
            position_reg   <= position_next;
            start_col_reg  <= start_col_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload, loaded with each accepted request.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg  <= res_next;
            last_reg <= last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(alt_pkg::OUT_DATA_W - RES_W)'(0), res_reg};
    assign m_tlast  = last_reg;

    // Checks on the scanner's own consistency.
    `ASSERT_IMPLIES(a_start_in_token, out_valid_reg && res_reg.token_start, res_reg.in_token)
    `ASSERT_IMPLIES(a_blank_clean, out_valid_reg && !res_reg.in_token,
        res_reg.token_column == '0 && !res_reg.is_quoted)
    `ASSERT_IMPLIES(a_error_at_eol, out_valid_reg && res_reg.quote_error, last_reg)
    `ASSERT_NEXT(a_eol_resets, accept && s_tlast,
        mode_reg == MODE_IDLE && position_reg == '0 && start_col_reg == '0)

endmodule

`default_nettype wire
